FILE: rtl/core/escaped_frame_receiver_crc16_assert.svh
// Assertion macros for the escaped frame receiver.
// Both expect clk and rst_n in scope.
`ifndef ESCAPED_FRAME_RECEIVER_CRC16_ASSERT_SVH
`define ESCAPED_FRAME_RECEIVER_CRC16_ASSERT_SVH

// same-cycle implication
`define EFR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define EFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/efr_crc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package efr_crc_pkg;

  localparam int FRAME_DEPTH_DEF = 64;
  localparam int MIN_FRAME       = 4;
  localparam int CRC_BYTES       = 2;

  localparam logic [7:0]  FLAG_BYTE = 8'h7E;
  localparam logic [7:0]  ESC_BYTE  = 8'h7D;
  localparam logic [7:0]  ESC_XOR   = 8'h20;
  localparam logic [15:0] CRC_POLY  = 16'h8408;

  localparam logic [7:0] ACK_CODE_RST   = 8'h00;
  localparam logic [7:0] READY_MASK_RST = 8'h80;

  // configuration register indexes
  localparam int          CFG_IDX_W      = 1;
  localparam logic [0:0]  REG_ACK_CODE   = 1'b0;
  localparam logic [0:0]  REG_READY_MASK = 1'b1;

  // frame kinds
  localparam logic [1:0] KIND_ACK   = 2'd0;
  localparam logic [1:0] KIND_READY = 2'd1;
  localparam logic [1:0] KIND_RESP  = 2'd2;

  typedef struct packed {
    logic take;       // store byte and advance CRC
    logic esc_xor;    // byte follows an escape
    logic clear;      // clear CRC, length, overflow
    logic rd_one;     // read command byte address
    logic cnt_clear;
    logic cnt_inc;
    logic kind_load;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic is_flag;
    logic is_esc;
    logic good;
    logic out_last;
  } dp_stat_t;

  // Kermit CRC-16, reflected, one byte
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/efr_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module efr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: rtl/core/efr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module efr_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  input  wire efr_crc_pkg::dp_stat_t stat,
  output efr_crc_pkg::dp_cmd_t       cmd
);
  import efr_crc_pkg::*;

  typedef enum logic [2:0] {
    S_WAIT, S_MSG, S_ESC, S_CMD, S_KIND, S_LOAD, S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  assign in_ready  = (state_r == S_WAIT) || (state_r == S_MSG) || (state_r == S_ESC);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_WAIT: begin
        if (accept && stat.is_flag) begin
          cmd.clear = 1'b1;
          state_nxt = S_MSG;
        end
      end
      S_MSG: begin
        if (accept) begin
          priority if (stat.is_esc) begin
            state_nxt = S_ESC;
          end else if (stat.is_flag) begin
            if (stat.good) begin
              state_nxt = S_CMD;
            end else begin
              cmd.clear = 1'b1;
            end
          end else begin
            cmd.take = 1'b1;
          end
        end
      end
      S_ESC: begin
        if (accept) begin
          cmd.take    = 1'b1;
          cmd.esc_xor = 1'b1;
          state_nxt   = S_MSG;
        end
      end
      S_CMD: begin
        cmd.rd_one    = 1'b1;
        cmd.cnt_clear = 1'b1;
        state_nxt     = S_KIND;
      end
      S_KIND: begin
        cmd.kind_load = 1'b1;
        state_nxt     = S_LOAD;
      end
      S_LOAD: begin
        cmd.out_load = 1'b1;
        state_nxt    = S_EMIT;
      end
      S_EMIT: begin
        if (out_ready) begin
          if (stat.out_last) begin
            cmd.clear = 1'b1;
            state_nxt = S_WAIT;
          end else begin
            cmd.cnt_inc = 1'b1;
            state_nxt   = S_LOAD;
          end
        end
      end
      default: state_nxt = S_WAIT;
    endcase
    out_valid_nxt = (state_nxt == S_EMIT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_WAIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/efr_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module efr_dpath #(
  parameter int FRAME_DEPTH = efr_crc_pkg::FRAME_DEPTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic [7:0]                          in_rx_byte,
  input  wire logic                                cfg_we,
  input  wire logic [efr_crc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [7:0]                          cfg_wdata,
  input  wire efr_crc_pkg::dp_cmd_t                cmd,
  output efr_crc_pkg::dp_stat_t                    stat,
  output logic [7:0]                               out_payload_byte,
  output logic [1:0]                               out_frame_kind,
  output logic                                     out_last
);
  import efr_crc_pkg::*;

  localparam int AW = $clog2(FRAME_DEPTH);
  localparam int LW = $clog2(FRAME_DEPTH + 1);

  logic [7:0]    ack_code_r, ready_mask_r;
  logic [15:0]   crc_r;
  logic [LW-1:0] len_r;
  logic          ovf_r;
  logic [AW-1:0] cnt_r;
  logic [1:0]    kind_r;
  logic [7:0]    byte_r;
  logic          last_r;

  logic [7:0]    data_in;
  logic          full;
  logic          ram_we;
  logic [AW-1:0] raddr;
  logic [7:0]    rdata;
  logic          is_last;

  assign data_in = cmd.esc_xor ? (in_rx_byte ^ ESC_XOR) : in_rx_byte;
  assign full    = (len_r == LW'(FRAME_DEPTH));
  assign ram_we  = cmd.take && !full;
  assign raddr   = cmd.rd_one  ? AW'(1) :
                   cmd.cnt_inc ? cnt_r + AW'(1) : cnt_r;
  assign is_last = (LW'(cnt_r) + LW'(1)) == (len_r - LW'(CRC_BYTES));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ack_code_r   <= ACK_CODE_RST;
      ready_mask_r <= READY_MASK_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ACK_CODE:   ack_code_r   <= cfg_wdata;
        REG_READY_MASK: ready_mask_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= '0;
      len_r <= '0;
      ovf_r <= 1'b0;
    end else if (cmd.clear) begin
      crc_r <= '0;
      len_r <= '0;
      ovf_r <= 1'b0;
    end else if (cmd.take) begin
      crc_r <= crc_step(crc_r, data_in);
      if (full) begin
        ovf_r <= 1'b1;
      end else begin
        len_r <= len_r + LW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.cnt_clear) begin
      cnt_r <= '0;
    end else if (cmd.cnt_inc) begin
      cnt_r <= cnt_r + AW'(1);
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.kind_load) begin
      if (rdata == ack_code_r) begin
        kind_r <= KIND_ACK;
      end else if ((rdata & ready_mask_r) != 8'h00) begin
        kind_r <= KIND_READY;
      end else begin
        kind_r <= KIND_RESP;
      end
    end
    if (cmd.out_load) begin
      byte_r <= rdata;
      last_r <= is_last;
    end
  end

  efr_ram #(
    .WIDTH(8),
    .DEPTH(FRAME_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(len_r[AW-1:0]),
    .wdata(data_in),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign stat.is_flag  = (in_rx_byte == FLAG_BYTE);
  assign stat.is_esc   = (in_rx_byte == ESC_BYTE);
  assign stat.good     = !ovf_r && (len_r >= LW'(MIN_FRAME)) && (crc_r == 16'h0000);
  assign stat.out_last = last_r;

  assign out_payload_byte = byte_r;
  assign out_frame_kind   = kind_r;
  assign out_last         = last_r;

endmodule

`default_nettype wire

FILE: rtl/core/escaped_frame_receiver_crc16.sv
// Channel   Direction  Handshake              Contents
// in_       input      in_valid / in_ready    in_rx_byte: raw byte from the link
// out_      output     out_valid / out_ready  out_payload_byte, out_frame_kind, out_last
// cfg_      input      cfg_valid / cfg_ready  cfg_index, cfg_wdata (0 ack_code, 1 ready_mask)
//
// Reception takes one byte per cycle; in_ready is high whenever no frame is being emitted.
// After a good frame's closing flag the FSM passes S_CMD, S_KIND and S_LOAD before the first
// payload byte, then S_LOAD and S_EMIT per byte, set by the registered read port of the store.
// Input is held off from the closing flag until the last payload transaction.
// rst_n is synchronous, active low; the frame store itself is not cleared.
// out_valid holds with its payload until out_ready; cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none

`include "escaped_frame_receiver_crc16_assert.svh"

module escaped_frame_receiver_crc16 #(
  parameter int FRAME_DEPTH = efr_crc_pkg::FRAME_DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // received bytes
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [7:0]                        in_rx_byte,
  // payload bytes of good frames
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [7:0]                             out_payload_byte,
  output logic [1:0]                             out_frame_kind,
  output logic                                   out_last,
  // register writes
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [efr_crc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]                        cfg_wdata
);
  import efr_crc_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // register writes never stall
  assign cfg_ready = 1'b1;

  // FSM: parser mode plus the emission sequence
  efr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // CRC, length, overflow, frame store and output registers
  efr_dpath #(
    .FRAME_DEPTH(FRAME_DEPTH)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_rx_byte      (in_rx_byte),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .cmd             (cmd),
    .stat            (stat),
    .out_payload_byte(out_payload_byte),
    .out_frame_kind  (out_frame_kind),
    .out_last        (out_last)
  );

  // input is never taken while a payload byte is on offer
  `EFR_ASSERT_NOW(a_no_rx_during_emit, out_valid, !in_ready, "input ready during emission")

  // kind is always one of the three defined codes
  `EFR_ASSERT_NOW(a_kind_legal, out_valid,
    out_frame_kind == KIND_ACK || out_frame_kind == KIND_READY || out_frame_kind == KIND_RESP,
    "undefined frame kind")

  // final payload transaction reopens the input
  `EFR_ASSERT_NEXT(a_last_reopens, out_valid && out_ready && out_last, in_ready && !out_valid,
    "input not reopened after last byte")

  // a non-final transaction is followed by the store read gap
  `EFR_ASSERT_NEXT(a_mid_frame_gap, out_valid && out_ready && !out_last,
    !out_valid && !in_ready, "unexpected state after mid-frame byte")

endmodule

`default_nettype wire
